// File: sv/bdpc_pkg.sv
// Package for the button debounce and press classifier.
// Holds shared widths, reset values, register indexes, types and a helper function.
// Has no dependencies.
package bdpc_pkg;

    // Fixed widths of the payload fields.
    localparam int LEVEL_WIDTH = 3;
    localparam int INDEX_WIDTH = 2;
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_ADDR_WIDTH = 1;

    // Default number of buttons and register reset values.
    localparam int DEFAULT_BUTTON_COUNT = 3;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [COUNT_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [COUNT_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DEBOUNCE_TICKS = 1'b0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_LONG_PRESS_TICKS = 1'b1;

    // One release event as produced by a button debouncer.
    typedef struct packed {
        logic                   long_press;
        logic [COUNT_WIDTH-1:0] duration;
    } bdpc_event_t;

    // Status of the event queue as seen by the top level.
    typedef struct packed {
        logic nonempty;
        logic last;
    } bdpc_queue_status_t;

    // Increment that stops at the top of the counter range.
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        r = (v == COUNT_MAX) ? v : v + 16'd1;
        return r;
    endfunction

endpackage

// File: sv/bdpc_button.sv
// Debouncer and press timer for a single button.
// Depends on bdpc_pkg for the counter width, saturating increment and event type.
module bdpc_button
    import bdpc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   upd_en,
    input  logic                   raw,
    input  logic [COUNT_WIDTH-1:0] debounce_ticks,
    input  logic [COUNT_WIDTH-1:0] long_press_ticks,
    output logic                   evt_valid,
    output bdpc_event_t            evt
);

    logic                   prev_raw_reg, prev_raw_next;
    logic                   stable_reg, stable_next;
    logic [COUNT_WIDTH-1:0] quiet_reg, quiet_next;
    logic [COUNT_WIDTH-1:0] press_reg, press_next;
    logic                   active_reg, active_next;

    logic [COUNT_WIDTH-1:0] press_adv;
    logic [COUNT_WIDTH-1:0] quiet_adv;
    logic                   level_change;

    // Advance both counters, then decide whether the raw level is accepted.
    always_comb begin
        press_adv    = active_reg ? sat_inc(press_reg) : press_reg;
        quiet_adv    = (raw != prev_raw_reg) ? '0 : sat_inc(quiet_reg);
        level_change = (quiet_adv > debounce_ticks) && (raw != stable_reg);

        prev_raw_next = raw;
        stable_next   = stable_reg;
        quiet_next    = quiet_adv;
        press_next    = press_adv;
        active_next   = active_reg;
        evt_valid     = 1'b0;

        if (level_change) begin
            stable_next = raw;
            if (!raw) begin
                press_next  = '0;
                active_next = 1'b1;
            end else if (active_reg) begin
                evt_valid   = 1'b1;
                active_next = 1'b0;
            end
        end

        evt.duration   = press_adv;
        evt.long_press = (press_adv >= long_press_ticks);

        // Only a tick actually taken may report a release.
        if (!upd_en) begin
            evt_valid = 1'b0;
        end
    end

    // Per-button state, updated once per transferred tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_raw_reg <= 1'b1;
            stable_reg   <= 1'b1;
            quiet_reg    <= '0;
            press_reg    <= '0;
            active_reg   <= 1'b0;
        end else if (upd_en) begin
            prev_raw_reg <= prev_raw_next;
            stable_reg   <= stable_next;
            quiet_reg    <= quiet_next;
            press_reg    <= press_next;
            active_reg   <= active_next;
        end
    end

endmodule

// File: sv/bdpc_event_queue.sv
// Holds the release events of one tick and hands them out in button order.
// Depends on bdpc_pkg for the event and status types.
module bdpc_event_queue
    import bdpc_pkg::*;
#(
    parameter int BUTTON_COUNT = DEFAULT_BUTTON_COUNT,
    parameter int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  logic [BUTTON_COUNT-1:0] load_valid,
    input  bdpc_event_t             load_evt [BUTTON_COUNT],
    input  logic                    pop,
    output bdpc_queue_status_t      status,
    output logic [IDX_W-1:0]        pick_index,
    output bdpc_event_t             pick_evt
);

    logic [BUTTON_COUNT-1:0] mask_reg, mask_next;
    bdpc_event_t             evt_reg [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] pick_onehot;
    logic [BUTTON_COUNT-1:0] remaining;

    // Lowest pending button wins.
    always_comb begin
        pick_index  = '0;
        pick_onehot = '0;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                pick_index  = IDX_W'(i);
                pick_onehot = BUTTON_COUNT'(1) << i;
            end
        end
        remaining       = mask_reg & ~pick_onehot;
        pick_evt        = evt_reg[pick_index];
        status.nonempty = |mask_reg;
        status.last     = (remaining == '0);
    end

    // A load only happens once the previous tick's events are gone.
    always_comb begin
        if (load) begin
            mask_next = load_valid;
        end else if (pop) begin
            mask_next = remaining;
        end else begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    // Event payloads need no reset; the pending mask qualifies them.
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                evt_reg[i] <= load_evt[i];
            end
        end
    end

endmodule

// File: sv/button_debounce_press_classifier.sv
// A transferred tick waits in the input register, then updates the debouncers and loads the
// queue; its events leave through the output register, one per cycle unless m_ready stalls.
// Throughput: one tick per cycle when it releases at most one button and m_ready does not
// stall; a tick releasing several buttons holds the input until its last event is popped.
// Reset: synchronous, active low; all buttons released and idle, registers at defaults.
// Top level; depends on bdpc_pkg, bdpc_button and bdpc_event_queue.
module button_debounce_press_classifier
    import bdpc_pkg::*;
#(
    parameter int BUTTON_COUNT = DEFAULT_BUTTON_COUNT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [COUNT_WIDTH-1:0]    cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [LEVEL_WIDTH-1:0]    s_button_levels,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [INDEX_WIDTH-1:0]    m_button_index,
    output logic                      m_event_kind,
    output logic [COUNT_WIDTH-1:0]    m_press_duration,
    output logic                      m_last_event
);

    localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    logic [COUNT_WIDTH-1:0] debounce_reg;
    logic [COUNT_WIDTH-1:0] long_press_reg;

    logic                   in_valid_reg;
    logic [LEVEL_WIDTH-1:0] in_levels_reg;

    logic                    in_take;
    logic                    pop;
    logic [BUTTON_COUNT-1:0] raw_vec;
    logic [BUTTON_COUNT-1:0] evt_valid;
    bdpc_event_t             evt [BUTTON_COUNT];

    bdpc_queue_status_t      q_status;
    logic [IDX_W-1:0]        pick_index;
    logic [IDX_W+1:0]        pick_index_ext;
    bdpc_event_t             pick_evt;

    logic                    m_valid_reg, m_valid_next;
    logic [INDEX_WIDTH-1:0]  m_index_reg;
    logic                    m_kind_reg;
    logic [COUNT_WIDTH-1:0]  m_duration_reg;
    logic                    m_last_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEBOUNCE_TICKS:   debounce_reg   <= cfg_wr_data;
                REG_LONG_PRESS_TICKS: long_press_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Handshake between the stages. The input register frees up as soon as the
    // queue is empty or is handing out the last event of the previous tick.
    assign pop     = q_status.nonempty && (!m_valid_reg || m_ready);
    assign in_take = in_valid_reg && (!q_status.nonempty || (pop && q_status.last));
    assign s_ready = !in_valid_reg || in_take;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_levels_reg <= s_button_levels;
        end
    end

    // One debouncer per button; buttons beyond the input pins see a pressed level.
    for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_button
        if (i < LEVEL_WIDTH) begin : g_pin
            assign raw_vec[i] = in_levels_reg[i];
        end else begin : g_tied
            assign raw_vec[i] = 1'b0;
        end

        bdpc_button u_button (
            .aclk             (aclk),
            .aresetn          (aresetn),
            .upd_en           (in_take),
            .raw              (raw_vec[i]),
            .debounce_ticks   (debounce_reg),
            .long_press_ticks (long_press_reg),
            .evt_valid        (evt_valid[i]),
            .evt              (evt[i])
        );
    end

    bdpc_event_queue #(
        .BUTTON_COUNT (BUTTON_COUNT),
        .IDX_W        (IDX_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (in_take),
        .load_valid (evt_valid),
        .load_evt   (evt),
        .pop        (pop),
        .status     (q_status),
        .pick_index (pick_index),
        .pick_evt   (pick_evt)
    );

    // The reported index keeps only the low bits of the button number.
    assign pick_index_ext = {2'b00, pick_index};

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_index_reg    <= pick_index_ext[INDEX_WIDTH-1:0];
            m_kind_reg     <= pick_evt.long_press;
            m_duration_reg <= pick_evt.duration;
            m_last_reg     <= q_status.last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_button_index   = m_index_reg;
    assign m_event_kind     = m_kind_reg;
    assign m_press_duration = m_duration_reg;
    assign m_last_event     = m_last_reg;

`ifndef SYNTHESIS
    // A new tick never overwrites events still waiting in the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |-> (!q_status.nonempty || (pop && q_status.last)))
        else $error("tick taken while release events are still pending");

    // An event not marked last always has a successor waiting in the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_event) |-> q_status.nonempty)
        else $error("event not marked last but no further event pending");

    // A short press is always shorter than the long press setting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_event_kind) |-> (m_press_duration < long_press_reg))
        else $error("short press reported with a long duration");

    // Every event popped from the queue is shown in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_valid)
        else $error("popped event did not reach the output register");
`endif

endmodule

// File: tb/tb_button_debounce_press_classifier.sv
// Self-checking testbench for the button debounce and press classifier.
// Holds a tick-level release-event predictor and a checker on the result channel.
// Depends on bdpc_pkg and button_debounce_press_classifier.
`timescale 1ns / 1ps

module tb_button_debounce_press_classifier
    import bdpc_pkg::*;
();

    localparam int BUTTONS      = DEFAULT_BUTTON_COUNT;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_TICKS   = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_TICKS  = 60;

    // One expected release event.
    typedef struct {
        logic [INDEX_WIDTH-1:0] button;
        logic                   kind_long;
        logic [COUNT_WIDTH-1:0] duration;
        logic                   last;
    } release_event_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr = REG_DEBOUNCE_TICKS;
    logic [COUNT_WIDTH-1:0]    cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [LEVEL_WIDTH-1:0]    s_button_levels = '1;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [INDEX_WIDTH-1:0]    m_button_index;
    logic                      m_event_kind;
    logic [COUNT_WIDTH-1:0]    m_press_duration;
    logic                      m_last_event;

    // Predictor state: configuration and per-button debouncer copy.
    logic [COUNT_WIDTH-1:0] debounce_cfg;
    logic [COUNT_WIDTH-1:0] long_cfg;
    logic                   last_raw [BUTTONS];
    logic                   settled [BUTTONS];
    logic [COUNT_WIDTH-1:0] quiet_ticks [BUTTONS];
    logic [COUNT_WIDTH-1:0] press_ticks [BUTTONS];
    logic                   pressing [BUTTONS];

    release_event_t pending_events [$];
    int             error_count = 0;
    int             cycle_count = 0;

    // Sender pacing and random level generator state.
    logic       gaps_enabled = 1'b1;
    int         burst_left = 0;
    logic       intended_level [BUTTONS];
    int         hold_left [BUTTONS];
    logic [9:0] rx_phase = '0;

    button_debounce_press_classifier dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_button_levels  (s_button_levels),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_button_index   (m_button_index),
        .m_event_kind     (m_event_kind),
        .m_press_duration (m_press_duration),
        .m_last_event     (m_last_event)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Bring the predictor to its post-reset state.
    task automatic reset_predictor();
        debounce_cfg = DEBOUNCE_RESET;
        long_cfg = LONG_PRESS_RESET;
        for (int b = 0; b < BUTTONS; b++) begin
            last_raw[b] = 1'b1;
            settled[b] = 1'b1;
            quiet_ticks[b] = '0;
            press_ticks[b] = '0;
            pressing[b] = 1'b0;
        end
    endtask

    // Advance every debouncer by one tick and queue the release events it yields.
    function automatic void predict_releases(input logic [LEVEL_WIDTH-1:0] levels);
        release_event_t ev;
        release_event_t found [$];
        logic           raw;
        for (int b = 0; b < BUTTONS; b++) begin
            raw = levels[b];
            if (pressing[b] && press_ticks[b] != COUNT_MAX)
                press_ticks[b] = press_ticks[b] + 1'b1;
            if (raw != last_raw[b])
                quiet_ticks[b] = '0;
            else if (quiet_ticks[b] != COUNT_MAX)
                quiet_ticks[b] = quiet_ticks[b] + 1'b1;
            if (quiet_ticks[b] > debounce_cfg && raw != settled[b]) begin
                settled[b] = raw;
                if (!raw) begin
                    press_ticks[b] = '0;
                    pressing[b] = 1'b1;
                end else if (pressing[b]) begin
                    ev.button = INDEX_WIDTH'(b);
                    ev.kind_long = (press_ticks[b] >= long_cfg);
                    ev.duration = press_ticks[b];
                    ev.last = 1'b0;
                    found.push_back(ev);
                    pressing[b] = 1'b0;
                end
            end
            last_raw[b] = raw;
        end
        // The final event of the tick carries the last flag.
        foreach (found[k]) begin
            ev = found[k];
            ev.last = (k == found.size() - 1);
            pending_events.push_back(ev);
        end
    endfunction

    // Offer one tick and wait for its transfer; bursts end in a random gap.
    task automatic send_tick(input logic [LEVEL_WIDTH-1:0] levels);
        int gap;
        s_valid <= 1'b1;
        s_button_levels <= levels;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_releases(levels);
        if (gaps_enabled) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 24);
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    // Hold the sender until every expected event has arrived and the block is idle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write both registers on consecutive cycles.
    task automatic write_config(input logic [COUNT_WIDTH-1:0] debounce,
                                input logic [COUNT_WIDTH-1:0] long_ticks);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_DEBOUNCE_TICKS;
        cfg_wr_data <= debounce;
        @(posedge aclk);
        cfg_addr <= REG_LONG_PRESS_TICKS;
        cfg_wr_data <= long_ticks;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        debounce_cfg = debounce;
        long_cfg = long_ticks;
    endtask

    // Levels that follow an intended press pattern with contact bounce and noise.
    function automatic logic [LEVEL_WIDTH-1:0] next_bouncy_levels();
        logic [LEVEL_WIDTH-1:0] lv;
        for (int b = 0; b < BUTTONS; b++) begin
            if (hold_left[b] == 0) begin
                intended_level[b] = ~intended_level[b];
                hold_left[b] = $urandom_range(1, int'(debounce_cfg) + 6);
            end
            hold_left[b]--;
            lv[b] = intended_level[b];
            if ($urandom_range(0, 9) == 0)
                lv[b] = ~lv[b];
        end
        if ($urandom_range(0, 19) == 0)
            lv = LEVEL_WIDTH'($urandom_range(0, 7));
        return lv;
    endfunction

    // Reset settings: a short press must not be accepted.
    task automatic test_reset_defaults();
        repeat (3) send_tick(3'b110);
    endtask

    // Zero debounce: single-button presses, a joint press of all three, and bounce.
    task automatic test_zero_debounce();
        logic [LEVEL_WIDTH-1:0] seq [22];
        seq = '{3'b111, 3'b110, 3'b110, 3'b110, 3'b110, 3'b111, 3'b111,
                3'b000, 3'b000, 3'b000, 3'b111, 3'b111,
                3'b101, 3'b111, 3'b101, 3'b101, 3'b111, 3'b111,
                3'b011, 3'b011, 3'b111, 3'b111};
        wait_drained();
        write_config(16'd0, 16'd3);
        foreach (seq[k]) send_tick(seq[k]);
    endtask

    // Bouncy press sequences over several register settings.
    task automatic test_random_traffic();
        logic [COUNT_WIDTH-1:0] deb_set [5];
        logic [COUNT_WIDTH-1:0] long_set [5];
        deb_set = '{16'd0, 16'd1, 16'd2, 16'd3, COUNT_WIDTH'($urandom_range(0, 4))};
        long_set = '{16'd0, 16'd5, COUNT_MAX, COUNT_WIDTH'($urandom_range(2, 10)),
                     COUNT_WIDTH'($urandom_range(0, 15))};
        for (int p = 0; p < 5; p++) begin
            wait_drained();
            write_config(deb_set[p], long_set[p]);
            for (int b = 0; b < BUTTONS; b++) begin
                intended_level[b] = 1'b0;
                hold_left[b] = 0;
            end
            repeat (PHASE_TICKS) send_tick(next_bouncy_levels());
        end
    endtask

    // Long holds: the largest debounce setting never accepts a level, and a press
    // whose duration equals the long setting is classed as long.
    task automatic test_long_hold();
        gaps_enabled = 1'b0;
        wait_drained();
        write_config(16'd0, COUNT_WIDTH'(HOLD_TICKS + 1));
        repeat (3) send_tick(3'b111);
        wait_drained();
        write_config(COUNT_MAX, COUNT_WIDTH'(HOLD_TICKS + 1));
        repeat (HOLD_TICKS) send_tick(3'b000);
        wait_drained();
        write_config(16'd0, COUNT_WIDTH'(HOLD_TICKS + 1));
        repeat (HOLD_TICKS) send_tick(3'b000);
        repeat (2) send_tick(3'b111);
        gaps_enabled = 1'b1;
    endtask

    // Receiver back-pressure: free running, random, sparse and long stalls in turn.
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 1'b1;
        case (rx_phase[9:8])
            2'd0: begin
                m_ready <= 1'b1;
            end
            2'd1: begin
                m_ready <= ($urandom_range(0, 1) == 1);
            end
            2'd2: begin
                m_ready <= (rx_phase[1:0] == 2'd0);
            end
            default: begin
                m_ready <= (rx_phase[3:0] > 4'd6);
            end
        endcase
    end

    // Compare each transferred event with the oldest expectation.
    always @(posedge aclk) begin
        release_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected event: button %0d kind %0d duration %0d last %0d",
                             m_button_index, m_event_kind, m_press_duration, m_last_event);
            end else begin
                want = pending_events.pop_front();
                if (m_button_index !== want.button || m_event_kind !== want.kind_long ||
                    m_press_duration !== want.duration || m_last_event !== want.last) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("event mismatch: expected button %0d kind %0d duration %0d last %0d",
                                 want.button, want.kind_long, want.duration, want.last);
                        $display("                got button %0d kind %0d duration %0d last %0d",
                                 m_button_index, m_event_kind, m_press_duration,
                                 m_last_event);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL button_debounce_press_classifier");
            $finish;
        end
    end

    initial begin
        reset_predictor();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_zero_debounce();
        test_random_traffic();
        test_long_hold();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS button_debounce_press_classifier");
        end else begin
            $display("FAIL button_debounce_press_classifier");
        end
        $finish;
    end

endmodule
